### src/csd_pkg.sv
// package for the concentric square-to-disk block
// widths, constants, arctangent table and the side-band struct
// no dependencies
`timescale 1ns / 1ps

package csd_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int ANGLE_STEPS = 16;
   localparam int FRAC_T      = 30;

   localparam int COORD_W = SAMPLE_BITS + 2;   // signed a, b and their negations
   localparam int MAG_W   = SAMPLE_BITS + 1;   // magnitudes up to 2^SAMPLE_BITS
   localparam int QUO_BITS = FRAC_T + 1;       // minor <= major, so quotient <= 2^30
   localparam int PI_W    = 30;
   localparam int PROD_W  = QUO_BITS + PI_W;
   localparam int Z_W     = 32;
   localparam int XY_W    = 33;
   localparam int SCL_W   = XY_W + MAG_W + 1;
   localparam int OUT_W   = 18;
   localparam int OUT_SH  = SAMPLE_BITS + FRAC_T - 16;

   localparam logic [PI_W-1:0]            PI_QUARTER_Q30 = PI_W'(843314857);
   localparam logic signed [XY_W-1:0]     GAIN_INV_Q30   = XY_W'(652032874);
   localparam logic signed [OUT_W-1:0]    OUT_MAX        = OUT_W'(65536);
   localparam logic signed [OUT_W-1:0]    OUT_MIN        = -OUT_W'(65536);

   localparam logic [31:0] ATAN_TAB [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
      32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic [1:0]       wedge;
      logic             neg;
      logic             zero;
      logic [MAG_W-1:0] radius;
   } side_type;

endpackage

### src/csd_if.sv
// beat channels for the concentric square-to-disk block
// depends on csd_pkg
`timescale 1ns / 1ps

interface csd_req_if;
   logic                               valid;
   logic                               ready;
   logic [csd_pkg::SAMPLE_BITS-1:0]    seed_x;
   logic [csd_pkg::SAMPLE_BITS-1:0]    seed_y;
   modport source (output valid, seed_x, seed_y, input ready);
   modport sink (input valid, seed_x, seed_y, output ready);
endinterface

interface csd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [csd_pkg::OUT_W-1:0]   disk_x;
   logic signed [csd_pkg::OUT_W-1:0]   disk_y;
   modport source (output valid, disk_x, disk_y, input ready);
   modport sink (input valid, disk_x, disk_y, output ready);
endinterface

### src/concentric_square_to_disk.sv
// top level: concentric square-to-disk mapping, fully pipelined
// depends on csd_pkg, csd_if (csd_req_if, csd_rsp_if) and csd_cordic
//
//   channel   dir   beat payload
//   req_bus   in    seed_x, seed_y (unsigned Q0.16)
//   rsp_bus   out   disk_x, disk_y (signed, 16 fraction bits)
//
// one beat in and one beat out per cycle while rsp_bus.ready is not holding the pipe; stages
// (input stage, 31 divider bit stages, 2 angle stages, 16 cordic stages,
// scale multiply, round and saturate)
// reset clears the stage valid bits only
// the whole pipe holds while a result waits and rsp_bus.ready is low
`timescale 1ns / 1ps

module concentric_square_to_disk (
   input  logic      clock,
   input  logic      reset,
   csd_req_if.sink   req_bus,
   csd_rsp_if.source rsp_bus
);
   import csd_pkg::*;

   logic adv;

   // input stage
   logic signed [COORD_W-1:0] a_s, b_s, num_s, den_s, r_s;
   logic [1:0]                wedge;
   logic                      st0_vld_ff;
   logic [MAG_W-1:0]          st0_num_ff, st0_den_ff;
   side_type                  st0_side_ff;
   side_type                  side_in;

   // divider
   logic                      dv_vld_ff  [QUO_BITS];
   logic [MAG_W-1:0]          dv_rem_ff  [QUO_BITS];
   logic [QUO_BITS-1:0]       dv_q_ff    [QUO_BITS];
   logic [MAG_W-1:0]          dv_den_ff  [QUO_BITS];
   side_type                  dv_side_ff [QUO_BITS];

   // angle
   logic                      pm_vld_ff, th_vld_ff;
   logic [PROD_W-1:0]         pm_prod_ff;
   side_type                  pm_side_ff, th_side_ff;
   logic [PROD_W-1:0]         th_sum;
   logic [QUO_BITS-1:0]       th_mag;
   logic signed [Z_W-1:0]     th_in, th_ff;

   // cordic and output
   logic                      cd_vld;
   logic signed [XY_W-1:0]    cd_x, cd_y, cx, cy;
   side_type                  cd_side;
   logic                      sc_vld_ff;
   logic signed [SCL_W-1:0]   sc_px_ff, sc_py_ff, px_in, py_in;
   logic                      sc_zero_ff;
   logic                      out_vld_ff;
   logic signed [OUT_W-1:0]   out_x_ff, out_y_ff, out_x_in, out_y_in;

   function automatic logic signed [OUT_W-1:0] round_sat(logic signed [SCL_W-1:0] p);
      logic signed [SCL_W:0] q;
      q = ($signed({p[SCL_W-1], p}) + $signed((SCL_W+1)'(1) <<< (OUT_SH - 1))) >>> OUT_SH;
      if (q > $signed((SCL_W+1)'(OUT_MAX))) begin
         return OUT_MAX;
      end else if (q < -$signed((SCL_W+1)'(OUT_MAX))) begin
         return OUT_MIN;
      end
      return q[OUT_W-1:0];
   endfunction

   assign adv           = !out_vld_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   // wedge select
   always_comb begin
      a_s = $signed({2'b00, req_bus.seed_x}) + $signed({2'b00, req_bus.seed_x})
          - $signed(COORD_W'(1) << SAMPLE_BITS);
      b_s = $signed({2'b00, req_bus.seed_y}) + $signed({2'b00, req_bus.seed_y})
          - $signed(COORD_W'(1) << SAMPLE_BITS);
      if (a_s > -b_s) begin
         if (a_s > b_s) begin
            wedge = 2'd0; r_s = a_s;  num_s = b_s;  den_s = a_s;
         end else begin
            wedge = 2'd1; r_s = b_s;  num_s = -a_s; den_s = b_s;
         end
      end else begin
         if (a_s < b_s) begin
            wedge = 2'd2; r_s = -a_s; num_s = b_s;  den_s = a_s;
         end else begin
            wedge = 2'd3; r_s = -b_s; num_s = -a_s; den_s = b_s;
         end
      end
      side_in.wedge  = wedge;
      side_in.neg    = num_s[COORD_W-1] ^ den_s[COORD_W-1];
      side_in.zero   = (den_s == '0);
      side_in.radius = r_s[MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st0_vld_ff <= 1'b0;
      end else if (adv) begin
         st0_vld_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st0_num_ff  <= num_s[COORD_W-1] ? MAG_W'(-num_s) : MAG_W'(num_s);
         st0_den_ff  <= den_s[COORD_W-1] ? MAG_W'(-den_s) : MAG_W'(den_s);
         st0_side_ff <= side_in;
      end
   end

   // restoring divider, one quotient bit per stage
   for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
      logic                vld_src;
      logic [MAG_W:0]      trial;
      logic [MAG_W-1:0]    den_src;
      logic [QUO_BITS-1:0] q_src;
      side_type            side_src;
      logic                take;

      if (j == 0) begin : g_first
         assign vld_src  = st0_vld_ff;
         assign trial    = {1'b0, st0_num_ff};
         assign den_src  = st0_den_ff;
         assign q_src    = '0;
         assign side_src = st0_side_ff;
      end else begin : g_rest
         assign vld_src  = dv_vld_ff[j-1];
         assign trial    = {dv_rem_ff[j-1], 1'b0};
         assign den_src  = dv_den_ff[j-1];
         assign q_src    = dv_q_ff[j-1];
         assign side_src = dv_side_ff[j-1];
      end

      assign take = (trial >= {1'b0, den_src});

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[j] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[j] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[j]  <= take ? MAG_W'(trial - {1'b0, den_src}) : MAG_W'(trial);
            dv_q_ff[j]    <= {q_src[QUO_BITS-2:0], take};
            dv_den_ff[j]  <= den_src;
            dv_side_ff[j] <= side_src;
         end
      end
   end

   // angle in q30 radians
   assign th_sum = pm_prod_ff + (PROD_W'(1) << (FRAC_T - 1));
   assign th_mag = th_sum[FRAC_T +: QUO_BITS];

   always_comb begin
      if (pm_side_ff.zero) begin
         th_in = '0;
      end else if (pm_side_ff.neg) begin
         th_in = -$signed({1'b0, th_mag});
      end else begin
         th_in = $signed({1'b0, th_mag});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pm_vld_ff <= 1'b0;
         th_vld_ff <= 1'b0;
      end else if (adv) begin
         pm_vld_ff <= dv_vld_ff[QUO_BITS-1];
         th_vld_ff <= pm_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pm_prod_ff <= PROD_W'(dv_q_ff[QUO_BITS-1]) * PROD_W'(PI_QUARTER_Q30);
         pm_side_ff <= dv_side_ff[QUO_BITS-1];
         th_ff      <= th_in;
         th_side_ff <= pm_side_ff;
      end
   end

   csd_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (th_vld_ff),
      .z_in      (th_ff),
      .side_in   (th_side_ff),
      .out_valid (cd_vld),
      .x_out     (cd_x),
      .y_out     (cd_y),
      .side_out  (cd_side)
   );

   // quarter turns, then scale by radius
   always_comb begin
      case (cd_side.wedge)
         2'd0:    begin cx = cd_x;  cy = cd_y;  end
         2'd1:    begin cx = -cd_y; cy = cd_x;  end
         2'd2:    begin cx = -cd_x; cy = -cd_y; end
         default: begin cx = cd_y;  cy = -cd_x; end
      endcase
      px_in = SCL_W'(cx) * $signed({1'b0, cd_side.radius});
      py_in = SCL_W'(cy) * $signed({1'b0, cd_side.radius});
   end

   assign out_x_in = sc_zero_ff ? '0 : round_sat(sc_px_ff);
   assign out_y_in = sc_zero_ff ? '0 : round_sat(sc_py_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         sc_vld_ff  <= cd_vld;
         out_vld_ff <= sc_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sc_px_ff   <= px_in;
         sc_py_ff   <= py_in;
         sc_zero_ff <= (cd_side.radius == '0);
         out_x_ff   <= out_x_in;
         out_y_ff   <= out_y_in;
      end
   end

   assign rsp_bus.valid  = out_vld_ff;
   assign rsp_bus.disk_x = out_x_ff;
   assign rsp_bus.disk_y = out_y_ff;

`ifndef ASSERT_OFF
   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(sc_vld_ff) && $stable(th_vld_ff) && $stable(st0_vld_ff))
      else $error("pipe moved during stall");

   a_range: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> out_x_ff <= OUT_MAX && out_x_ff >= OUT_MIN
                  && out_y_ff <= OUT_MAX && out_y_ff >= OUT_MIN)
      else $error("disk point out of range");

   a_origin: assert property (@(posedge clock) disable iff (reset)
      adv && sc_vld_ff && sc_zero_ff |=> out_x_ff == '0 && out_y_ff == '0)
      else $error("origin not mapped to zero");

   a_quotient: assert property (@(posedge clock) disable iff (reset)
      dv_vld_ff[QUO_BITS-1] && !dv_side_ff[QUO_BITS-1].zero
      |-> dv_q_ff[QUO_BITS-1] <= (QUO_BITS'(1) << FRAC_T))
      else $error("slope above one");
`endif

endmodule

### src/csd_cordic.sv
// pipelined rotation-mode cordic, one iteration per register stage
// depends on csd_pkg
`timescale 1ns / 1ps

module csd_cordic (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [csd_pkg::Z_W-1:0]    z_in,
   input  csd_pkg::side_type                 side_in,
   output logic                              out_valid,
   output logic signed [csd_pkg::XY_W-1:0]   x_out,
   output logic signed [csd_pkg::XY_W-1:0]   y_out,
   output csd_pkg::side_type                 side_out
);
   import csd_pkg::*;

   logic                   vld_ff  [ANGLE_STEPS];
   logic signed [XY_W-1:0] x_ff    [ANGLE_STEPS];
   logic signed [XY_W-1:0] y_ff    [ANGLE_STEPS];
   logic signed [Z_W-1:0]  z_ff    [ANGLE_STEPS];
   side_type               side_ff [ANGLE_STEPS];

   for (genvar i = 0; i < ANGLE_STEPS; i++) begin : g_step
      logic                   vld_src;
      logic signed [XY_W-1:0] x_src, y_src, x_in, y_in;
      logic signed [Z_W-1:0]  z_src, z_in_n;
      side_type               side_src;

      if (i == 0) begin : g_first
         assign vld_src  = in_valid;
         assign x_src    = GAIN_INV_Q30;
         assign y_src    = '0;
         assign z_src    = z_in;
         assign side_src = side_in;
      end else begin : g_rest
         assign vld_src  = vld_ff[i-1];
         assign x_src    = x_ff[i-1];
         assign y_src    = y_ff[i-1];
         assign z_src    = z_ff[i-1];
         assign side_src = side_ff[i-1];
      end

      always_comb begin
         if (!z_src[Z_W-1]) begin
            x_in   = x_src - (y_src >>> i);
            y_in   = y_src + (x_src >>> i);
            z_in_n = z_src - $signed(ATAN_TAB[i]);
         end else begin
            x_in   = x_src + (y_src >>> i);
            y_in   = y_src - (x_src >>> i);
            z_in_n = z_src + $signed(ATAN_TAB[i]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            z_ff[i]    <= z_in_n;
            side_ff[i] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[ANGLE_STEPS-1];
   assign x_out     = x_ff[ANGLE_STEPS-1];
   assign y_out     = y_ff[ANGLE_STEPS-1];
   assign side_out  = side_ff[ANGLE_STEPS-1];

endmodule
